@@ rtl/irg_pkg.sv @@
// ----------------------------------------------------------------------------
// irg_pkg: shared types and constants of the radius graph edge generator
// Field widths, register indexes, item kinds, unit operand structs and the
// disk half-width helper.
// ----------------------------------------------------------------------------
`default_nettype none

package irg_pkg;

   // field widths
   localparam int CFG_W      = 9;
   localparam int LEV_W      = 8;
   localparam int IDX_W      = 16;
   localparam int PIX_W      = 8;
   localparam int WEIGHT_W   = 16;
   localparam int REQ_DATA_W = IDX_W + PIX_W;
   localparam int RSP_DATA_W = IDX_W + IDX_W + WEIGHT_W;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVELS = 2'd2;

   // request kinds on tuser
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_EXPAND = 1'b1;

   // defaults of the top level parameters
   localparam int DEF_RADIUS   = 3;
   localparam int DEF_MAX_SIDE = 256;
   localparam int MAX_RADIUS   = 4;

   // squared distance, sqrt and divider operand widths
   localparam int S_W       = 5;               // dy^2+dx^2 <= 16
   localparam int X2_W      = 20;              // levels^2 * s
   localparam int SQ_FRAC_W = 26;              // (2^13)^2 scale
   localparam int SQ_IN_W   = X2_W + SQ_FRAC_W;
   localparam int SQ_OUT_W  = SQ_IN_W / 2;
   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 10;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
      logic [DIV_DEN_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic               start;
      logic [SQ_IN_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic                done;
      logic [SQ_OUT_W-1:0] root;
   } sqrt_rsp_type;

   // largest |dx| with dx^2 + ady^2 <= r^2
   function automatic int disk_half(input int r, input int ady);
      int w;
      w = 0;
      for (int k = 0; k <= MAX_RADIUS; k++) begin
         if (k * k + ady * ady <= r * r) begin
            w = k;
         end
      end
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/irg_div.sv @@
// ----------------------------------------------------------------------------
// irg_div: iterative restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module irg_div (
   input  wire                  clock,
   input  wire                  reset,
   input  irg_pkg::div_req_type div_req,
   output irg_pkg::div_rsp_type div_rsp
);

   localparam int NUM_W = irg_pkg::DIV_NUM_W;
   localparam int DEN_W = irg_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   part;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      part    = {rem_ff, quo_ff[NUM_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (part >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(part - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = part[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   always_comb begin
      div_rsp.done      = done_ff;
      div_rsp.quotient  = quo_ff;
      div_rsp.remainder = rem_ff;
   end

endmodule

`default_nettype wire

@@ rtl/irg_sqrt.sv @@
// ----------------------------------------------------------------------------
// irg_sqrt: digit-by-digit integer square root
// One root bit per cycle, floor of the square root; done pulses after it.
// ----------------------------------------------------------------------------
`default_nettype none

module irg_sqrt (
   input  wire                   clock,
   input  wire                   reset,
   input  irg_pkg::sqrt_req_type sq_req,
   output irg_pkg::sqrt_rsp_type sq_rsp
);

   localparam int IN_W  = irg_pkg::SQ_IN_W;
   localparam int OUT_W = irg_pkg::SQ_OUT_W;
   localparam int REM_W = OUT_W + 3;
   localparam int PRE_W = REM_W + 2;
   localparam int CNT_W = $clog2(OUT_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IN_W-1:0]  rad_ff, rad_in;
   logic [OUT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [PRE_W-1:0] pre, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      pre     = {rem_ff, rad_ff[IN_W-1:IN_W-2]};
      trial   = PRE_W'({root_ff, 2'b01});
      if (sq_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = sq_req.radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (pre >= trial) begin
            rem_in  = REM_W'(pre - trial);
            root_in = {root_ff[OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(pre);
            root_in = {root_ff[OUT_W-2:0], 1'b0};
         end
         rad_in = {rad_ff[IN_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(OUT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   always_comb begin
      sq_rsp.done = done_ff;
      sq_rsp.root = root_ff;
   end

endmodule

`default_nettype wire

@@ rtl/image_radius_graph_edges.sv @@
// ----------------------------------------------------------------------------
// image_radius_graph_edges: radius graph edge generator over a gray frame
// Frame store, expand sequencer, shared divider and square-root unit.
// ----------------------------------------------------------------------------
// Usage
//   req channel: tuser = kind (load / expand), tdata = pixel index, value.
//   A load writes one gray pixel into the frame store; req_tready stays high.
//   An expand transaction names a center pixel. The block walks the disk of
//   radius RADIUS around it in raster order, clipped to the image, and puts
//   one rsp transaction out per neighbor not darker than the center; the
//   last one carries rsp_tlast. A center outside the image yields nothing.
//   req_tready is low from the expand until its last edge is handed to the
//   output register.
//   Steps: setup and the center row/col divide, then per visited pixel
//   address, read and compare, plus a row step per disk row, plus for an
//   emitted edge the numerator, the weight divide and the hand-off, plus
//   the square root before them when off center and RADIUS>1. The
//   iterative divider and square root take most of the time per edge.
//   A single output register holds a result; a stalled receiver holds up the
//   sequencer only when an edge must move into it while it is still full.
//   Reset (synchronous) empties the output and restores the register
//   defaults; the frame store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module image_radius_graph_edges #(
   parameter int RADIUS   = irg_pkg::DEF_RADIUS,
   parameter int MAX_SIDE = irg_pkg::DEF_MAX_SIDE
) (
   input  wire                               clock,
   input  wire                               reset,
   // req_tdata: pixel_index[15:0], pixel_value[23:16]
   // req_tuser: action (0 load, 1 expand)
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [irg_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                               req_tuser,
   // rsp_tdata: source_vertex[15:0], neighbor_vertex[31:16],
   //            edge_weight[47:32] (signed Q2.14); rsp_tlast: last_edge
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [irg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  wire                               csr_we,
   input  wire  [irg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [irg_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int IDX_W   = irg_pkg::IDX_W;
   localparam int PIX_W   = irg_pkg::PIX_W;
   localparam int LEV_W   = irg_pkg::LEV_W;
   localparam int CFG_W   = irg_pkg::CFG_W;
   localparam int W_W     = irg_pkg::WEIGHT_W;
   localparam int S_W     = irg_pkg::S_W;
   localparam int X2_W    = irg_pkg::X2_W;
   localparam int NUM_W   = irg_pkg::DIV_NUM_W;
   localparam int DEN_W   = irg_pkg::DIV_DEN_W;
   localparam int ROOT_W  = irg_pkg::SQ_OUT_W;
   // off-center weights saturate at 4.0 (2^16 in Q2.14), which wraps to zero
   localparam int Q_CAP   = 65536;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SETUP = 4'd1;
   localparam logic [3:0] ST_CWAIT = 4'd2;
   localparam logic [3:0] ST_ROW   = 4'd3;
   localparam logic [3:0] ST_ADDR  = 4'd4;
   localparam logic [3:0] ST_READ  = 4'd5;
   localparam logic [3:0] ST_CMP   = 4'd6;
   localparam logic [3:0] ST_SQRT  = 4'd7;
   localparam logic [3:0] ST_NUM   = 4'd8;
   localparam logic [3:0] ST_WDIV  = 4'd9;
   localparam logic [3:0] ST_EMIT  = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   // request fields
   logic             action;
   logic [IDX_W-1:0] pixel_index;
   logic [PIX_W-1:0] pixel_value;

   assign action      = req_tuser;
   assign pixel_index = req_tdata[IDX_W-1:0];
   assign pixel_value = req_tdata[IDX_W+PIX_W-1:IDX_W];

   // configuration registers
   logic [CFG_W-1:0] rows_cfg_ff;
   logic [CFG_W-1:0] cols_cfg_ff;
   logic [LEV_W-1:0] lev_cfg_ff;

   // sequencer registers
   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SIDE_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [LEV_W-1:0]  lev_ff, lev_in;
   logic [2*LEV_W-1:0] lev2_ff, lev2_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [SIDE_W-1:0] ci_ff, ci_in, cj_ff, cj_in;
   logic [SIDE_W-1:0] y_ff, y_in, yhi_ff, yhi_in;
   logic [SIDE_W-1:0] x_ff, x_in, xhi_ff, xhi_in;
   logic [PIX_W-1:0]  cval_ff, cval_in, diff_ff, diff_in;
   logic [S_W-1:0]    s_ff, s_in;
   logic [IDX_W-1:0]  nidx_ff, nidx_in;
   logic [ROOT_W-1:0] f_ff, f_in;
   logic              neg_ff, neg_in;
   logic [W_W-1:0]    w_ff, w_in;

   // pending edge: held back until we know whether it is the last one
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_nidx_ff, pend_nidx_in;
   logic [W_W-1:0]    pend_w_ff, pend_w_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  out_src_ff, out_src_in;
   logic [IDX_W-1:0]  out_nidx_ff, out_nidx_in;
   logic [W_W-1:0]    out_w_ff, out_w_in;
   logic              out_last_ff, out_last_in;
   logic              out_free;
   logic              advance;

   // frame store
   logic [PIX_W-1:0]  frame_mem [DEPTH];
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [PIX_W-1:0]  mem_wdata, mem_q;

   // shared units
   irg_pkg::div_req_type  div_req;
   irg_pkg::div_rsp_type  div_rsp;
   irg_pkg::sqrt_req_type sq_req;
   irg_pkg::sqrt_rsp_type sq_rsp;
   logic [X2_W-1:0]       x2;

   assign x2 = X2_W'(lev2_ff) * X2_W'(s_ff);

   irg_div u_irg_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   irg_sqrt u_irg_sqrt (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      int t, dy, dx, wh, lo, hi, mag;
      state_in      = state_ff;
      idx_in        = idx_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      lev_in        = lev_ff;
      lev2_in       = lev2_ff;
      den_in        = den_ff;
      ci_in         = ci_ff;
      cj_in         = cj_ff;
      y_in          = y_ff;
      yhi_in        = yhi_ff;
      x_in          = x_ff;
      xhi_in        = xhi_ff;
      cval_in       = cval_ff;
      diff_in       = diff_ff;
      s_in          = s_ff;
      nidx_in       = nidx_ff;
      f_in          = f_ff;
      neg_in        = neg_ff;
      w_in          = w_ff;
      pend_valid_in = pend_valid_ff;
      pend_nidx_in  = pend_nidx_ff;
      pend_w_in     = pend_w_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_src_in    = out_src_ff;
      out_nidx_in   = out_nidx_ff;
      out_w_in      = out_w_ff;
      out_last_in   = out_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = ADDR_W'(pixel_index);
      mem_wdata     = pixel_value;
      mem_re        = 1'b0;
      mem_raddr     = ADDR_W'(nidx_ff);
      div_req       = '0;
      sq_req        = '0;
      advance       = 1'b0;
      t   = 0;
      dy  = 0;
      dx  = 0;
      wh  = 0;
      lo  = 0;
      hi  = 0;
      mag = 0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (action == irg_pkg::ACT_LOAD) begin
                  mem_we = (int'(pixel_index) < DEPTH);
               end else begin
                  idx_in = pixel_index;
                  // saturate image size to 1..MAX_SIDE, zero levels act as 1
                  if (rows_cfg_ff == '0) rows_in = SIDE_W'(1);
                  else if (rows_cfg_ff > CFG_W'(MAX_SIDE)) rows_in = SIDE_W'(MAX_SIDE);
                  else rows_in = SIDE_W'(rows_cfg_ff);
                  if (cols_cfg_ff == '0) cols_in = SIDE_W'(1);
                  else if (cols_cfg_ff > CFG_W'(MAX_SIDE)) cols_in = SIDE_W'(MAX_SIDE);
                  else cols_in = SIDE_W'(cols_cfg_ff);
                  lev_in   = (lev_cfg_ff == '0) ? LEV_W'(1) : lev_cfg_ff;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (int'(idx_ff) >= int'(rows_ff) * int'(cols_ff)) begin
               state_in = ST_IDLE;
            end else begin
               mem_re           = 1'b1;
               mem_raddr        = ADDR_W'(idx_ff);
               div_req.start    = 1'b1;
               div_req.dividend = NUM_W'(idx_ff);
               div_req.divisor  = DEN_W'(cols_ff);
               lev2_in          = {LEV_W'(0), lev_ff} * {LEV_W'(0), lev_ff};
               if (RADIUS == 1) den_in = DEN_W'(lev_ff);
               else den_in = DEN_W'(int'(lev_ff) * (RADIUS - 1));
               pend_valid_in    = 1'b0;
               state_in         = ST_CWAIT;
            end
         end
         ST_CWAIT: begin
            if (div_rsp.done) begin
               ci_in   = SIDE_W'(div_rsp.quotient);
               cj_in   = SIDE_W'(div_rsp.remainder);
               cval_in = mem_q;
               lo = int'(SIDE_W'(div_rsp.quotient)) - RADIUS;
               hi = int'(SIDE_W'(div_rsp.quotient)) + RADIUS;
               y_in   = (lo < 0) ? '0 : SIDE_W'(lo);
               yhi_in = (hi > int'(rows_ff) - 1) ? SIDE_W'(int'(rows_ff) - 1) : SIDE_W'(hi);
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            // clip the disk's row span to the image
            dy = int'(y_ff) - int'(ci_ff);
            wh = irg_pkg::disk_half(RADIUS, (dy < 0) ? -dy : dy);
            lo = int'(cj_ff) - wh;
            hi = int'(cj_ff) + wh;
            x_in   = (lo < 0) ? '0 : SIDE_W'(lo);
            xhi_in = (hi > int'(cols_ff) - 1) ? SIDE_W'(int'(cols_ff) - 1) : SIDE_W'(hi);
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            dy = int'(y_ff) - int'(ci_ff);
            dx = int'(x_ff) - int'(cj_ff);
            nidx_in  = IDX_W'(int'(y_ff) * int'(cols_ff) + int'(x_ff));
            s_in     = S_W'(dy * dy + dx * dx);
            state_in = ST_READ;
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (cval_ff > mem_q) begin
               advance = 1'b1;
            end else begin
               diff_in = mem_q - cval_ff;
               if (RADIUS == 1 || s_ff == '0) begin
                  f_in     = '0;
                  state_in = ST_NUM;
               end else begin
                  // floor(2^13 * levels * sqrt(s))
                  sq_req.start    = 1'b1;
                  sq_req.radicand = {x2, {irg_pkg::SQ_FRAC_W{1'b0}}};
                  state_in        = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            if (sq_rsp.done) begin
               f_in     = sq_rsp.root;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            if (RADIUS == 1) begin
               t = 16384 * int'(diff_ff);
            end else begin
               t = 8192 * int'(diff_ff) * (RADIUS - 1) - 8192 * int'(lev_ff) + int'(f_ff);
            end
            mag              = (t < 0) ? -t : t;
            neg_in           = (t < 0);
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'(mag);
            div_req.divisor  = den_ff;
            state_in         = ST_WDIV;
         end
         ST_WDIV: begin
            if (div_rsp.done) begin
               if (RADIUS > 1 && s_ff != '0 && div_rsp.quotient > NUM_W'(Q_CAP)) begin
                  w_in = W_W'(Q_CAP);
               end else begin
                  w_in = neg_ff ? W_W'(-W_W'(div_rsp.quotient)) : W_W'(div_rsp.quotient);
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!pend_valid_ff) begin
               pend_valid_in = 1'b1;
               pend_nidx_in  = nidx_ff;
               pend_w_in     = w_ff;
               advance       = 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               out_src_in   = idx_ff;
               out_nidx_in  = pend_nidx_ff;
               out_w_in     = pend_w_ff;
               out_last_in  = 1'b0;
               pend_nidx_in = nidx_ff;
               pend_w_in    = w_ff;
               advance      = 1'b1;
            end
         end
         ST_DONE: begin
            // the center always yields an edge, so one is pending here
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_src_in    = idx_ff;
               out_nidx_in   = pend_nidx_ff;
               out_w_in      = pend_w_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next disk position in raster order
      if (advance) begin
         if (x_ff == xhi_ff) begin
            if (y_ff == yhi_ff) begin
               state_in = ST_DONE;
            end else begin
               y_in     = y_ff + 1'b1;
               state_in = ST_ROW;
            end
         end else begin
            x_in     = x_ff + 1'b1;
            state_in = ST_ADDR;
         end
      end
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rows_cfg_ff   <= CFG_W'(256);
         cols_cfg_ff   <= CFG_W'(256);
         lev_cfg_ff    <= LEV_W'(255);
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               irg_pkg::CSR_ROWS:   rows_cfg_ff <= csr_wdata;
               irg_pkg::CSR_COLS:   cols_cfg_ff <= csr_wdata;
               irg_pkg::CSR_LEVELS: lev_cfg_ff  <= csr_wdata[LEV_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      rows_ff      <= rows_in;
      cols_ff      <= cols_in;
      lev_ff       <= lev_in;
      lev2_ff      <= lev2_in;
      den_ff       <= den_in;
      ci_ff        <= ci_in;
      cj_ff        <= cj_in;
      y_ff         <= y_in;
      yhi_ff       <= yhi_in;
      x_ff         <= x_in;
      xhi_ff       <= xhi_in;
      cval_ff      <= cval_in;
      diff_ff      <= diff_in;
      s_ff         <= s_in;
      nidx_ff      <= nidx_in;
      f_ff         <= f_in;
      neg_ff       <= neg_in;
      w_ff         <= w_in;
      pend_nidx_ff <= pend_nidx_in;
      pend_w_ff    <= pend_w_in;
      out_src_ff   <= out_src_in;
      out_nidx_ff  <= out_nidx_in;
      out_w_ff     <= out_w_in;
      out_last_ff  <= out_last_in;
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q <= frame_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_w_ff, out_nidx_ff, out_src_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

@@ rtl/irg_checker.sv @@
// ----------------------------------------------------------------------------
// irg_checker: port-level checks of the radius graph edge generator
// Reset behavior, load and expand handshake timing, output hold on stall.
// ----------------------------------------------------------------------------
`default_nettype none

module irg_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            req_tuser,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [irg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire                            rsp_tlast
);

   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("not ready after reset");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == irg_pkg::ACT_LOAD |=> req_tready)
      else $error("load transaction did not complete in one cycle");

   a_expand_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == irg_pkg::ACT_EXPAND |=> !req_tready)
      else $error("ready during expand");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind image_radius_graph_edges irg_checker u_irg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ tb/sv/image_radius_graph_edges_checker.sv @@
// ----------------------------------------------------------------------------
// image_radius_graph_edges_checker: edge predictor and result scoreboard
// Watches the req, rsp and csr ports. It mirrors the frame store and the
// registers, computes the edges of each expand and compares every rsp
// transaction with the oldest edge still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module image_radius_graph_edges_checker #(
   parameter int RADIUS   = irg_pkg::DEF_RADIUS,
   parameter int MAX_SIDE = irg_pkg::DEF_MAX_SIDE
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire  [irg_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                               req_tuser,
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire  [irg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                               rsp_tlast,
   input  wire                               csr_we,
   input  wire  [irg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [irg_pkg::CFG_W-1:0]         csr_wdata,
   output int                                edges_owed,
   output int                                fail_count
);

   localparam int IDX_W = irg_pkg::IDX_W;
   localparam int W_W   = irg_pkg::WEIGHT_W;
   localparam int PIX_W = irg_pkg::PIX_W;
   localparam int CFG_W = irg_pkg::CFG_W;
   localparam int LEV_W = irg_pkg::LEV_W;

   typedef struct {
      logic [IDX_W-1:0]      src;
      logic [IDX_W-1:0]      nbr;
      logic signed [W_W-1:0] weight;
      logic                  last;
   } graph_edge_type;

   graph_edge_type   owed_edges[$];
   logic [PIX_W-1:0] pixels[65536];
   logic [CFG_W-1:0] rows_reg, cols_reg;
   logic [LEV_W-1:0] levels_reg;

   assign edges_owed = owed_edges.size();

   initial begin
      fail_count = 0;
      for (int i = 0; i < 65536; i++) pixels[i] = '0;
   end

   task automatic report(input string what);
      fail_count++;
      $display("mismatch @%0t: %s", $time, what);
   endtask

   function automatic longint side_of(input longint v);
      if (v < 1) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
   endfunction

   // Q2.14 weight from squared distance and intensity difference, truncated
   function automatic longint q_weight(input longint sq, input longint diff,
                                       input longint lev);
      longint a, b, den, lo, hi, q, rhs;
      if (RADIUS == 1) return (diff * 16384) / lev;
      a   = 8192 * lev;
      b   = 8192 * (diff * (RADIUS - 1) - lev);
      den = lev * (RADIUS - 1);
      if (sq == 0) return b / den;
      // largest q with a*sqrt(sq) + b >= q*den, by bisection
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
         q   = (lo + hi + 1) / 2;
         rhs = q * den - b;
         if (rhs <= 0 || a * a * sq >= rhs * rhs) lo = q;
         else hi = q - 1;
      end
      return lo;
   endfunction

   task automatic predict_expand(input longint idx);
      longint rows, cols, lev, ci, cj, cval, y, x, sq, nidx, nval;
      graph_edge_type e;
      int first;
      rows = side_of(rows_reg);
      cols = side_of(cols_reg);
      lev  = (levels_reg == 0) ? 1 : levels_reg;
      if (idx >= rows * cols) return;
      first = owed_edges.size();
      ci   = idx / cols;
      cj   = idx % cols;
      cval = pixels[idx];
      for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
         y = ci + dy;
         if (y < 0 || y >= rows) continue;
         for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            x  = cj + dx;
            sq = dy * dy + dx * dx;
            if (x < 0 || x >= cols || sq > RADIUS * RADIUS) continue;
            nidx = y * cols + x;
            nval = pixels[nidx[15:0]];
            if (cval > nval) continue;
            e.src    = idx[15:0];
            e.nbr    = nidx[15:0];
            e.weight = W_W'(q_weight(sq, nval - cval, lev));
            e.last   = 1'b0;
            owed_edges.push_back(e);
         end
      end
      if (owed_edges.size() > first) owed_edges[owed_edges.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rows_reg   <= 9'd256;
         cols_reg   <= 9'd256;
         levels_reg <= 8'd255;
      end else begin
         if (csr_we) begin
            case (csr_index)
               irg_pkg::CSR_ROWS:   rows_reg   <= csr_wdata;
               irg_pkg::CSR_COLS:   cols_reg   <= csr_wdata;
               irg_pkg::CSR_LEVELS: levels_reg <= csr_wdata[LEV_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == irg_pkg::ACT_LOAD) pixels[req_tdata[15:0]] = req_tdata[23:16];
            else predict_expand(req_tdata[15:0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_edges.size() == 0) begin
               report($sformatf("unexpected edge %h", rsp_tdata));
            end else begin
               graph_edge_type e;
               e = owed_edges.pop_front();
               if (rsp_tdata[15:0] !== e.src)
                  report($sformatf("source %0d, want %0d", rsp_tdata[15:0], e.src));
               if (rsp_tdata[31:16] !== e.nbr)
                  report($sformatf("neighbor %0d, want %0d", rsp_tdata[31:16], e.nbr));
               if (rsp_tdata[47:32] !== e.weight)
                  report($sformatf("weight %0d, want %0d (src %0d nbr %0d)",
                         $signed(rsp_tdata[47:32]), e.weight, e.src, e.nbr));
               if (rsp_tlast !== e.last)
                  report($sformatf("last %b, want %b (src %0d nbr %0d)",
                         rsp_tlast, e.last, e.src, e.nbr));
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/image_radius_graph_edges_tb.sv @@
// ----------------------------------------------------------------------------
// image_radius_graph_edges_tb: stimulus and verdict for the edge generator
// Runs several image sizes and level settings, extremes among them. Each
// phase loads the pixels an expand will read, then sends directed and
// random expands and loads, stalling both channels at random when not
// steady; the checker beside the block predicts and scores every edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module image_radius_graph_edges_tb;

   localparam int RADIUS   = irg_pkg::DEF_RADIUS;
   localparam int MAX_SIDE = irg_pkg::DEF_MAX_SIDE;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [irg_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = irg_pkg::ACT_LOAD;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [irg_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_we = 1'b0;
   logic [irg_pkg::CSR_IDX_W-1:0]  csr_index = irg_pkg::CSR_ROWS;
   logic [irg_pkg::CFG_W-1:0]      csr_wdata = '0;
   int                             edges_owed, fail_count;

   // no random idling on either side while set
   bit steady = 1'b0;
   // pixels loaded so far; an expand never reads one that is not
   bit loaded[65536];
   int rows_now = 256, cols_now = 256;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   image_radius_graph_edges #(.RADIUS(RADIUS), .MAX_SIDE(MAX_SIDE)) DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_we, .csr_index, .csr_wdata
   );

   image_radius_graph_edges_checker #(.RADIUS(RADIUS), .MAX_SIDE(MAX_SIDE)) u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_we, .csr_index, .csr_wdata, .edges_owed, .fail_count
   );

   // receiver drops ready about 18 percent of the time outside steady stretches
   always @(posedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 18);
   end

   // hard stop in case the block hangs
   initial begin
      #60ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // one req transaction; valid stays high when the next one follows at once
   task automatic send(input logic act, input int idx, input int val);
      if (!steady && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {val[7:0], idx[15:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == irg_pkg::ACT_LOAD) loaded[idx[15:0]] = 1'b1;
   endtask

   task automatic load_pixel(input int idx, input int val);
      send(irg_pkg::ACT_LOAD, idx, val);
   endtask

   // loads every unwritten pixel of the disk, then expands the center
   task automatic expand(input int idx);
      int r, c, y, x;
      if (idx < rows_now * cols_now) begin
         r = idx / cols_now;
         c = idx % cols_now;
         for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
            for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
               y = r + dy;
               x = c + dx;
               if (y < 0 || y >= rows_now || x < 0 || x >= cols_now) continue;
               if (dy * dy + dx * dx > RADIUS * RADIUS) continue;
               if (!loaded[y * cols_now + x])
                  load_pixel(y * cols_now + x, $urandom_range(255));
            end
         end
      end
      send(irg_pkg::ACT_EXPAND, idx, $urandom_range(255));
   endtask

   // random center in the top-left 4x4 corner: clipped and full disks,
   // with few new pixels to load
   function automatic int near_corner();
      int r, c;
      r = $urandom_range(((rows_now < 4) ? rows_now : 4) - 1);
      c = $urandom_range(((cols_now < 4) ? cols_now : 4) - 1);
      return r * cols_now + c;
   endfunction

   // registers change only once the block has drained
   task automatic configure(input int rows, input int cols, input int levels);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (edges_owed != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_we <= 1'b1; csr_index <= irg_pkg::CSR_ROWS; csr_wdata <= rows[8:0];
      @(posedge clock);
      csr_index <= irg_pkg::CSR_COLS; csr_wdata <= cols[8:0];
      @(posedge clock);
      csr_index <= irg_pkg::CSR_LEVELS; csr_wdata <= levels[8:0];
      @(posedge clock);
      csr_we <= 1'b0;
      rows_now = (rows < 1) ? 1 : (rows > MAX_SIDE) ? MAX_SIDE : rows;
      cols_now = (cols < 1) ? 1 : (cols > MAX_SIDE) ? MAX_SIDE : cols;
   endtask

   task automatic random_traffic(input int count);
      int area;
      area = rows_now * cols_now;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0: load_pixel($urandom_range(65535), $urandom_range(255));
            1: if (area < 65536) expand($urandom_range(65535, area));
               else expand(near_corner());
            2, 3: begin
               // reload one corner pixel, then expand a corner center
               int v;
               v = $urandom_range(250);
               load_pixel(near_corner(), v + $urandom_range(5));
               expand(near_corner());
            end
            default: expand(near_corner());
         endcase
      end
   endtask

   initial begin
      int settings[8][3] = '{
         '{256, 256, 255}, '{0, 511, 0}, '{511, 1, 1}, '{5, 7, 100},
         '{16, 16, 37}, '{2, 3, 255}, '{1, 1, 128}, '{9, 12, 1}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full-size image at reset values: corners, middle, edge values
      steady = 1'b1;
      load_pixel(65535, 255);
      load_pixel(0, 0);
      expand(0);
      expand(65535);
      load_pixel(128 * 256 + 128, 0);
      expand(128 * 256 + 128);
      load_pixel(300, 255);
      expand(300);
      steady = 1'b0;
      random_traffic(6);

      foreach (settings[p]) begin
         configure(settings[p][0], settings[p][1], settings[p][2]);
         steady = (p == 3);
         expand(0);
         expand(rows_now * cols_now - 1);
         if (rows_now * cols_now < 65536) expand(65535);
         random_traffic(6);
      end
      steady = 1'b0;
      configure(256, 256, 255);
      random_traffic(10);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (edges_owed != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/irg_pkg.sv
rtl/irg_div.sv
rtl/irg_sqrt.sv
rtl/image_radius_graph_edges.sv
rtl/irg_checker.sv
tb/sv/image_radius_graph_edges_checker.sv
tb/sv/image_radius_graph_edges_tb.sv
